// ===== src/uet_pkg.sv =====
// Shared types and constants of the ultrasonic echo timer.
package uet_pkg;

    localparam int DEF_NUM_SENSORS = 4;
    localparam int DEF_COUNT_WIDTH = 24;

    localparam int SENS_W     = 4;
    localparam int RD_W       = 2;
    localparam int DUR_W      = 24;
    localparam int TIMEOUT_W  = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam int TRIG_CNT_W = 4;

    localparam logic [TRIG_CNT_W-1:0] TRIG_LEN  = 4'd12;
    localparam logic [TRIG_CNT_W-1:0] TRIG_HIGH = 4'd10;
    localparam logic [DUR_W-1:0]      DUR_MAX   = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT  = 1'b0,
        CFG_OWN_TRIG = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic             trig;
        logic             idle;
        logic             timed_out;
        logic [DUR_W-1:0] duration;
    } t_lane_out;

    typedef struct packed {
        logic [SENS_W-1:0] trigger_levels;
        logic [SENS_W-1:0] idle_mask;
        logic [DUR_W-1:0]  duration;
        logic              timed_out;
    } t_result;

endpackage

// ===== src/uet_lane.sv =====
// One sensor lane: measurement phase, counters and trigger pulse timer.
module uet_lane
    import uet_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_acc,
    input  logic                 i_start,
    input  logic                 i_fire,
    input  logic                 i_echo,
    input  logic                 i_echo_prev,
    input  logic [TIMEOUT_W-1:0] i_timeout,
    output t_lane_out            o_out
);

    localparam int CMP_W = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_STARTED = 3'b010,
        PH_RUNNING = 3'b100
    } t_phase;

    t_phase                  r_phase, n_phase;
    logic [COUNT_WIDTH-1:0]  r_since, n_since;
    logic [COUNT_WIDTH-1:0]  r_rise, n_rise;
    logic [COUNT_WIDTH-1:0]  r_width, n_width;
    logic                    r_tout, n_tout;
    logic [TRIG_CNT_W-1:0]   r_trig_cnt, n_trig_cnt;

    logic [COUNT_WIDTH-1:0]  w_inc;
    logic                    w_rise_edge;
    logic                    w_fall_edge;
    logic                    w_expired;

    assign w_inc       = (r_since != CNT_MAX) ? r_since + 1'b1 : r_since;
    assign w_rise_edge = i_echo && !i_echo_prev;
    assign w_fall_edge = !i_echo && i_echo_prev;
    assign w_expired   = (i_timeout != '0) && (CMP_W'(w_inc) > CMP_W'(i_timeout));

    always_comb begin
        n_phase = r_phase;
        n_since = r_since;
        n_rise  = r_rise;
        n_width = r_width;
        n_tout  = r_tout;
        if (i_start) begin
            n_phase = PH_STARTED;
            n_since = '0;
            n_rise  = '0;
            n_width = '0;
            n_tout  = 1'b0;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                end
                PH_STARTED: begin
                    n_since = w_inc;
                    if (w_rise_edge) begin
                        n_rise  = w_inc;
                        n_phase = PH_RUNNING;
                    end else if (w_expired) begin
                        n_phase = PH_IDLE;
                        n_width = '0;
                        n_tout  = 1'b1;
                    end
                end
                PH_RUNNING: begin
                    n_since = w_inc;
                    if (w_fall_edge) begin
                        n_width = w_inc - r_rise;
                        n_phase = PH_IDLE;
                    end else if (w_expired) begin
                        n_phase = PH_IDLE;
                        n_width = '0;
                        n_tout  = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        if (i_fire) begin
            n_trig_cnt = TRIG_LEN;
        end else if (r_trig_cnt != '0) begin
            n_trig_cnt = r_trig_cnt - 1'b1;
        end else begin
            n_trig_cnt = r_trig_cnt;
        end
    end

    always_comb begin
        o_out.trig      = (n_trig_cnt != '0) && (n_trig_cnt <= TRIG_HIGH);
        o_out.idle      = (n_phase == PH_IDLE);
        o_out.timed_out = n_tout;
        if (CMP_W'(n_width) > CMP_W'(DUR_MAX)) begin
            o_out.duration = DUR_MAX;
        end else begin
            o_out.duration = DUR_W'(n_width);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_since    <= '0;
            r_rise     <= '0;
            r_width    <= '0;
            r_tout     <= 1'b0;
            r_trig_cnt <= '0;
        end else if (i_acc) begin
            r_phase    <= n_phase;
            r_since    <= n_since;
            r_rise     <= n_rise;
            r_width    <= n_width;
            r_tout     <= n_tout;
            r_trig_cnt <= n_trig_cnt;
        end
    end

endmodule

// ===== src/uet_merge.sv =====
// Merges lane results into one transaction and buffers it (output + skid).
module uet_merge
    import uet_pkg::*;
#(
    parameter int NUM_SENSORS = DEF_NUM_SENSORS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_acc,
    input  t_lane_out       i_lanes [NUM_SENSORS],
    input  logic [RD_W-1:0] i_read_sensor,
    input  logic            i_stall,
    output logic            o_valid,
    output logic            o_stall,
    output t_result         o_result
);

    t_result w_res;
    t_result r_out, r_skid;
    logic    r_out_valid, r_skid_valid;

    always_comb begin
        w_res = '0;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            if (i < SENS_W) begin
                w_res.trigger_levels[i] = i_lanes[i].trig;
                w_res.idle_mask[i]      = i_lanes[i].idle;
            end
            if (int'(i_read_sensor) == i) begin
                w_res.duration  = i_lanes[i].duration;
                w_res.timed_out = i_lanes[i].timed_out;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out        <= w_res;
                r_out_valid  <= i_acc;
            end
        end else if (i_acc) begin
            r_skid       <= w_res;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_stall  = r_skid_valid;
    assign o_result = r_out;

endmodule

// ===== src/ultrasonic_echo_timer.sv =====
// Top level: ultrasonic echo timer with one lane per sensor.
// Each accepted result is registered, in the skid entry under output stall. One
// transaction per cycle while o_stall is low; all sensor lanes update in the same
// cycle. A two-entry output buffer (output register plus skid) keeps input flowing
// while the skid is free. Synchronous active-low reset: every sensor idle,
// counters, lane results and trigger timers zero, timeout 0, own-trigger mask 1.
module ultrasonic_echo_timer
    import uet_pkg::*;
#(
    parameter int NUM_SENSORS = DEF_NUM_SENSORS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_action,
    input  logic [SENS_W-1:0]     i_echo_levels,
    input  logic [SENS_W-1:0]     i_sensor_mask,
    input  logic [RD_W-1:0]       i_read_sensor,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [SENS_W-1:0]     o_trigger_levels,
    output logic [SENS_W-1:0]     o_idle_mask,
    output logic [DUR_W-1:0]      o_selected_duration,
    output logic                  o_selected_timed_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [TIMEOUT_W-1:0]   r_timeout;
    logic [SENS_W-1:0]      r_own_trig;
    logic [SENS_W-1:0]      r_prev_echo;

    logic                   w_acc;
    logic [NUM_SENSORS-1:0] w_start;
    logic [NUM_SENSORS-1:0] w_own;
    logic [NUM_SENSORS-1:0] w_echo;
    logic [NUM_SENSORS-1:0] w_echo_prev;
    logic [NUM_SENSORS-1:0] w_fire;
    t_lane_out              w_lanes [NUM_SENSORS];
    t_result                w_result;

    assign w_acc = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= '0;
            r_own_trig <= SENS_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_TIMEOUT:  r_timeout  <= i_cfg_data[TIMEOUT_W-1:0];
                CFG_OWN_TRIG: r_own_trig <= i_cfg_data[SENS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_echo <= '0;
        end else if (w_acc) begin
            r_prev_echo <= i_echo_levels;
        end
    end

    for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_map
        if (g < SENS_W) begin : g_pin
            assign w_start[g]     = i_action && i_sensor_mask[g];
            assign w_own[g]       = r_own_trig[g];
            assign w_echo[g]      = i_echo_levels[g];
            assign w_echo_prev[g] = r_prev_echo[g];
        end else begin : g_nopin
            assign w_start[g]     = 1'b0;
            assign w_own[g]       = 1'b0;
            assign w_echo[g]      = 1'b0;
            assign w_echo_prev[g] = 1'b0;
        end
    end

    // sensors without their own line fire the shared line 0
    always_comb begin
        w_fire = '0;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            if (w_start[i]) begin
                if (i != 0 && w_own[i]) begin
                    w_fire[i] = 1'b1;
                end else begin
                    w_fire[0] = 1'b1;
                end
            end
        end
    end

    for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
        uet_lane #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_acc       (w_acc),
            .i_start     (w_start[g]),
            .i_fire      (w_fire[g]),
            .i_echo      (w_echo[g]),
            .i_echo_prev (w_echo_prev[g]),
            .i_timeout   (r_timeout),
            .o_out       (w_lanes[g])
        );
    end

    uet_merge #(
        .NUM_SENSORS (NUM_SENSORS)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (w_acc),
        .i_lanes       (w_lanes),
        .i_read_sensor (i_read_sensor),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_stall       (o_stall),
        .o_result      (w_result)
    );

    assign o_trigger_levels     = w_result.trigger_levels;
    assign o_idle_mask          = w_result.idle_mask;
    assign o_selected_duration  = w_result.duration;
    assign o_selected_timed_out = w_result.timed_out;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("skid entry held without output entry");

    a_timeout_zero_dur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_selected_timed_out) |-> (o_selected_duration == '0))
        else $error("timed out measurement with nonzero duration");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !o_valid && i_action && i_sensor_mask[0])
        |=> (o_valid && !o_idle_mask[0] && !o_trigger_levels[0]))
        else $error("started sensor 0 not busy or trigger not low");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !o_valid && i_action && i_sensor_mask[0]
            && (i_read_sensor == '0))
        |=> (o_selected_duration == '0 && !o_selected_timed_out))
        else $error("started sensor 0 result not cleared");

endmodule
